// ----- rtl/core/tbp_pkg.sv -----
package tbp_pkg;

    localparam int BIMODAL_ENTRIES = 2048;
    localparam int GSHARE_ENTRIES  = 4096;
    localparam int CHOOSER_ENTRIES = 2048;

    localparam int BIM_IDX_W = $clog2(BIMODAL_ENTRIES);
    localparam int GSH_IDX_W = $clog2(GSHARE_ENTRIES);
    localparam int CHO_IDX_W = $clog2(CHOOSER_ENTRIES);

    // The clearing sweep has to reach every entry of the largest table.
    localparam int CLR_W_BG  = (BIM_IDX_W > GSH_IDX_W) ? BIM_IDX_W : GSH_IDX_W;
    localparam int CLR_W     = (CLR_W_BG > CHO_IDX_W) ? CLR_W_BG : CHO_IDX_W;

    localparam int PC_W   = 32;
    localparam int HIST_W = 16;
    localparam int LEN_W  = 5;
    localparam int CTR_W  = 2;

    localparam logic [LEN_W-1:0] HIST_LEN_RESET = 5'd12;
    localparam logic [CTR_W-1:0] CTR_RESET      = 2'd2;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_UPDATE = 2'd1;
    localparam logic [1:0] REQ_SQUASH = 2'd2;
    localparam logic [1:0] REQ_UNCOND = 2'd3;

    typedef logic [BIM_IDX_W-1:0] t_bim_idx;
    typedef logic [GSH_IDX_W-1:0] t_gsh_idx;
    typedef logic [CHO_IDX_W-1:0] t_cho_idx;
    typedef logic [CTR_W-1:0]     t_ctr;
    typedef logic [HIST_W-1:0]    t_hist;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [PC_W-1:0] branch_pc;
        logic            taken;
        logic            squashed;
        t_ctr            saved_local_ctr;
        t_ctr            saved_global_ctr;
        t_hist           saved_history;
    } t_tbp_req;

    typedef struct packed {
        logic  predict_taken;
        t_ctr  snap_local_ctr;
        t_ctr  snap_global_ctr;
        t_hist snap_history;
    } t_tbp_rsp;

    // Lengths above the history width saturate to a full mask.
    function automatic t_hist hist_mask(input logic [LEN_W-1:0] len);
        t_hist m;
        for (int i = 0; i < HIST_W; i++) begin
            m[i] = (len > LEN_W'(i));
        end
        return m;
    endfunction

    function automatic t_ctr train(input t_ctr c, input logic up);
        t_ctr r;
        r = c;
        if (up && c != 2'd3) begin
            r = c + 2'd1;
        end else if (!up && c != 2'd0) begin
            r = c - 2'd1;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/tbp_if.sv -----
interface tbp_req_if import tbp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_tbp_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tbp_rsp_if import tbp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_tbp_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/tournament_branch_predictor.sv -----
// The accept edge reads the three counter memories into registers; at the next
// edge an unsquashed update trains and writes back its counters, the history is
// updated and the result register is loaded. Only one item is in flight: no new
// item is accepted until the last one has written back, nor while a result waits.
// After reset the block sweeps all GSHARE_ENTRIES (4096) entries, one per cycle,
// writing the counter reset value; no item is accepted until the sweep ends.
module tournament_branch_predictor import tbp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata,
    tbp_req_if.sink          i_req,
    tbp_rsp_if.source        o_rsp
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CLR_W-1:0] r_clr_idx, n_clr_idx;
    t_hist            r_hist, n_hist;
    logic [LEN_W-1:0] r_hist_len, n_hist_len;
    logic             r_out_vld, n_out_vld;
    t_tbp_rsp         r_out, n_out;

    // Item held during the execute cycle.
    logic [1:0] r_req_type;
    logic       r_taken;
    logic       r_squashed;
    t_ctr       r_sloc;
    t_ctr       r_sglob;
    t_hist      r_shist;
    t_bim_idx   r_bim_idx;
    t_gsh_idx   r_gsh_idx;
    t_cho_idx   r_cho_idx;

    t_ctr r_bim_mem [BIMODAL_ENTRIES];
    t_ctr r_gsh_mem [GSHARE_ENTRIES];
    t_ctr r_cho_mem [CHOOSER_ENTRIES];
    t_ctr r_bim_q;
    t_ctr r_gsh_q;
    t_ctr r_cho_q;

    logic                 w_in_rdy;
    logic                 w_acc;
    logic [PC_W-3:0]      w_pcw;
    t_hist                w_gsh_hist;
    t_bim_idx             w_bim_ridx;
    t_gsh_idx             w_gsh_ridx;
    t_cho_idx             w_cho_ridx;
    t_hist                w_mask;
    logic                 w_clearing;
    logic                 w_train;
    logic                 w_bim_we, w_gsh_we, w_cho_we;
    t_bim_idx             w_bim_waddr;
    t_gsh_idx             w_gsh_waddr;
    t_cho_idx             w_cho_waddr;
    t_ctr                 w_bim_wdata, w_gsh_wdata, w_cho_wdata;
    logic                 w_pred;
    t_hist                w_exec_hist;
    t_tbp_rsp             w_rsp;

    assign w_in_rdy    = (r_state == ST_IDLE) && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = w_in_rdy;
    assign w_acc       = i_req.valid && w_in_rdy;
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

    assign w_mask = hist_mask(r_hist_len);

    // Read addresses, formed on the accept cycle. An update indexes gshare with
    // the history it saved at lookup time, not the live one.
    assign w_pcw      = i_req.data.branch_pc[PC_W-1:2];
    assign w_gsh_hist = (i_req.data.req_type == REQ_UPDATE)
                        ? (i_req.data.saved_history & w_mask) : r_hist;
    assign w_bim_ridx = w_pcw[BIM_IDX_W-1:0];
    assign w_cho_ridx = w_pcw[CHO_IDX_W-1:0];
    assign w_gsh_ridx = w_pcw[GSH_IDX_W-1:0] ^ t_gsh_idx'(w_gsh_hist);

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_req_type <= i_req.data.req_type;
            r_taken    <= i_req.data.taken;
            r_squashed <= i_req.data.squashed;
            r_sloc     <= i_req.data.saved_local_ctr;
            r_sglob    <= i_req.data.saved_global_ctr;
            r_shist    <= i_req.data.saved_history;
            r_bim_idx  <= w_bim_ridx;
            r_gsh_idx  <= w_gsh_ridx;
            r_cho_idx  <= w_cho_ridx;
        end
    end

    // Write-back: the sweep after reset, or the training of an unsquashed update.
    assign w_clearing = (r_state == ST_CLEAR);
    assign w_train    = (r_state == ST_EXEC) && (r_req_type == REQ_UPDATE) && !r_squashed;

    assign w_bim_we = w_clearing
                      ? ({1'b0, r_clr_idx} < (CLR_W + 1)'(BIMODAL_ENTRIES)) : w_train;
    assign w_gsh_we = w_clearing
                      ? ({1'b0, r_clr_idx} < (CLR_W + 1)'(GSHARE_ENTRIES)) : w_train;
    // The chooser learns only when the two components disagreed.
    assign w_cho_we = w_clearing
                      ? ({1'b0, r_clr_idx} < (CLR_W + 1)'(CHOOSER_ENTRIES))
                      : (w_train && (r_sloc[1] != r_sglob[1]));

    assign w_bim_waddr = w_clearing ? r_clr_idx[BIM_IDX_W-1:0] : r_bim_idx;
    assign w_gsh_waddr = w_clearing ? r_clr_idx[GSH_IDX_W-1:0] : r_gsh_idx;
    assign w_cho_waddr = w_clearing ? r_clr_idx[CHO_IDX_W-1:0] : r_cho_idx;

    assign w_bim_wdata = w_clearing ? CTR_RESET : train(r_bim_q, r_taken);
    assign w_gsh_wdata = w_clearing ? CTR_RESET : train(r_gsh_q, r_taken);
    assign w_cho_wdata = w_clearing ? CTR_RESET : train(r_cho_q, r_sglob[1] == r_taken);

    always_ff @(posedge i_clk) begin
        if (w_bim_we) begin
            r_bim_mem[w_bim_waddr] <= w_bim_wdata;
        end
        if (w_acc) begin
            r_bim_q <= r_bim_mem[w_bim_ridx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_gsh_we) begin
            r_gsh_mem[w_gsh_waddr] <= w_gsh_wdata;
        end
        if (w_acc) begin
            r_gsh_q <= r_gsh_mem[w_gsh_ridx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cho_we) begin
            r_cho_mem[w_cho_waddr] <= w_cho_wdata;
        end
        if (w_acc) begin
            r_cho_q <= r_cho_mem[w_cho_ridx];
        end
    end

    always_comb begin
        w_pred      = 1'b0;
        w_exec_hist = r_hist;
        w_rsp       = '0;
        case (r_req_type)
            REQ_LOOKUP: begin
                w_pred                = r_cho_q[1] ? r_gsh_q[1] : r_bim_q[1];
                w_exec_hist           = {r_hist[HIST_W-2:0], w_pred} & w_mask;
                w_rsp.snap_local_ctr  = r_bim_q;
                w_rsp.snap_global_ctr = r_gsh_q;
            end
            REQ_SQUASH: begin
                w_exec_hist = r_shist & w_mask;
            end
            REQ_UNCOND: begin
                w_pred      = 1'b1;
                w_exec_hist = {r_hist[HIST_W-2:0], 1'b1} & w_mask;
            end
            default: begin
                w_exec_hist = r_hist;
            end
        endcase
        w_rsp.predict_taken = w_pred;
        w_rsp.snap_history  = r_hist;
    end

    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        n_hist    = r_hist;
        n_out_vld = r_out_vld;
        n_out     = r_out;
        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_acc) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state   = ST_IDLE;
                n_out_vld = 1'b1;
                n_out     = w_rsp;
                n_hist    = w_exec_hist;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
        // A new length cuts the live history at once.
        if (i_cfg_we) begin
            n_hist = r_hist & hist_mask(i_cfg_wdata);
        end
        n_hist_len = i_cfg_we ? i_cfg_wdata : r_hist_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_idx  <= '0;
            r_hist     <= '0;
            r_hist_len <= HIST_LEN_RESET;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_idx  <= n_clr_idx;
            r_hist     <= n_hist;
            r_hist_len <= n_hist_len;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_hist_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hist & ~hist_mask(r_hist_len)) == '0)
        else $error("global history holds bits beyond the configured length");

    a_rsp_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(i_req.valid && i_req.ready, 2))
        else $error("result appeared without an accepted item two cycles earlier");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> !(w_bim_we || w_gsh_we || w_cho_we))
        else $error("counter write collides with a read on the accept cycle");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second item accepted while one is still executing");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb import tbp_pkg::*; ();

    localparam t_ctr CTR_TAKEN_MIN  = 2'd2;
    localparam t_ctr CTR_MAX        = 2'd3;
    localparam t_ctr CTR_MIN        = 2'd0;
    localparam int   NUM_PHASES     = 8;
    localparam int   PHASE_ITEMS    = 166;
    localparam int   SNAP_POOL_SIZE = 32;

    typedef struct {
        t_tbp_req rq;
        bit       typed;
        t_tbp_rsp rsp;
    } t_dir_row;

    typedef struct {
        logic [PC_W-1:0] pc;
        t_ctr            lctr;
        t_ctr            gctr;
        t_hist           hist;
    } t_lookup_snap;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [LEN_W-1:0] i_cfg_wdata;

    tbp_req_if req_if ();
    tbp_rsp_if rsp_if ();

    tournament_branch_predictor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    // Predictor state.
    t_ctr             bim_ctr [BIMODAL_ENTRIES];
    t_ctr             gsh_ctr [GSHARE_ENTRIES];
    t_ctr             cho_ctr [CHOOSER_ENTRIES];
    t_hist            spec_history;
    logic [LEN_W-1:0] hist_len;

    t_tbp_rsp     pending_rsp [$];
    t_lookup_snap lookup_snaps [$];
    t_dir_row     dir_rows [$];
    logic [PC_W-1:0] hot_pcs [16];

    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    int unsigned err_count;

    int unsigned src_idle_plan [4] = '{0, 76, 0, 17};
    int unsigned snk_stall_plan [4] = '{0, 0, 76, 17};
    logic [LEN_W-1:0] len_plan [NUM_PHASES] = '{5'd0, 5'd1, 5'd16, 5'd31,
                                                5'd17, 5'd5, 5'd12, 5'd11};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_hist len_mask(input logic [LEN_W-1:0] len);
        if (len >= HIST_W) return '1;
        return t_hist'((32'd1 << len) - 32'd1);
    endfunction

    function automatic t_ctr step_ctr(input t_ctr c, input logic up);
        if (up) return (c == CTR_MAX) ? c : c + 2'd1;
        return (c == CTR_MIN) ? c : c - 2'd1;
    endfunction

    task automatic model_reset();
        foreach (bim_ctr[i]) bim_ctr[i] = CTR_RESET;
        foreach (gsh_ctr[i]) gsh_ctr[i] = CTR_RESET;
        foreach (cho_ctr[i]) cho_ctr[i] = CTR_RESET;
        spec_history = '0;
        hist_len = HIST_LEN_RESET;
    endtask

    function automatic t_tbp_rsp predict_branch(input t_tbp_req r);
        t_tbp_rsp        o;
        logic [PC_W-3:0] pcw;
        t_hist           hx;
        t_hist           hm;
        t_bim_idx        bi;
        t_gsh_idx        gi;
        t_cho_idx        ci;
        t_ctr            lc;
        t_ctr            gc;
        logic            lp;
        logic            gp;
        pcw = r.branch_pc[PC_W-1:2];
        hm = len_mask(hist_len);
        bi = t_bim_idx'(pcw);
        ci = t_cho_idx'(pcw);
        o = '0;
        o.snap_history = spec_history;
        case (r.req_type)
            REQ_LOOKUP: begin
                hx = spec_history & hm;
                gi = t_gsh_idx'(pcw) ^ t_gsh_idx'(hx);
                lc = bim_ctr[bi];
                gc = gsh_ctr[gi];
                if (cho_ctr[ci] >= CTR_TAKEN_MIN) begin
                    o.predict_taken = (gc >= CTR_TAKEN_MIN);
                end else begin
                    o.predict_taken = (lc >= CTR_TAKEN_MIN);
                end
                o.snap_local_ctr = lc;
                o.snap_global_ctr = gc;
                spec_history = {spec_history[HIST_W-2:0], o.predict_taken} & hm;
            end
            REQ_UPDATE: begin
                if (!r.squashed) begin
                    // Training uses the history saved at lookup, not the live one.
                    hx = r.saved_history & hm;
                    gi = t_gsh_idx'(pcw) ^ t_gsh_idx'(hx);
                    lp = (r.saved_local_ctr >= CTR_TAKEN_MIN);
                    gp = (r.saved_global_ctr >= CTR_TAKEN_MIN);
                    if (lp != gp) begin
                        cho_ctr[ci] = step_ctr(cho_ctr[ci], gp == r.taken);
                    end
                    bim_ctr[bi] = step_ctr(bim_ctr[bi], r.taken);
                    gsh_ctr[gi] = step_ctr(gsh_ctr[gi], r.taken);
                end
            end
            REQ_SQUASH: begin
                spec_history = r.saved_history & hm;
            end
            REQ_UNCOND: begin
                o.predict_taken = 1'b1;
                spec_history = {spec_history[HIST_W-2:0], 1'b1} & hm;
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic t_tbp_req mk_req(input logic [1:0] kind, input logic [PC_W-1:0] pc,
                                        input logic tk, input logic sq, input t_ctr sl,
                                        input t_ctr sg, input t_hist sh);
        t_tbp_req r;
        r.req_type = kind;
        r.branch_pc = pc;
        r.taken = tk;
        r.squashed = sq;
        r.saved_local_ctr = sl;
        r.saved_global_ctr = sg;
        r.saved_history = sh;
        return r;
    endfunction

    task automatic add_row(input t_tbp_req rq, input bit typed, input t_tbp_rsp rsp);
        t_dir_row row;
        row.rq = rq;
        row.typed = typed;
        row.rsp = rsp;
        dir_rows.push_back(row);
    endtask

    // Random items favor lookups and updates that hand back real lookup snapshots.
    function automatic t_tbp_req gen_item();
        t_tbp_req     r;
        int unsigned  sel;
        t_lookup_snap s;
        r.branch_pc = ($urandom_range(9) < 7) ? hot_pcs[$urandom_range(15)] : $urandom;
        r.taken = 1'($urandom_range(1));
        r.squashed = ($urandom_range(9) == 0);
        r.saved_local_ctr = t_ctr'($urandom_range(3));
        r.saved_global_ctr = t_ctr'($urandom_range(3));
        r.saved_history = t_hist'($urandom);
        sel = $urandom_range(99);
        if (sel < 40) begin
            r.req_type = REQ_LOOKUP;
        end else if (sel < 75) begin
            r.req_type = REQ_UPDATE;
            if (lookup_snaps.size() != 0 && $urandom_range(9) < 8) begin
                s = lookup_snaps[$urandom_range(lookup_snaps.size() - 1)];
                r.branch_pc = s.pc;
                r.saved_local_ctr = s.lctr;
                r.saved_global_ctr = s.gctr;
                r.saved_history = s.hist;
                // A per-branch bias lets the counters saturate.
                r.taken = ($urandom_range(3) != 0) ? s.pc[4] : ~s.pc[4];
            end
        end else if (sel < 85) begin
            r.req_type = REQ_SQUASH;
            if (lookup_snaps.size() != 0 && $urandom_range(9) < 7) begin
                r.saved_history = lookup_snaps[$urandom_range(lookup_snaps.size() - 1)].hist;
            end
        end else begin
            r.req_type = REQ_UNCOND;
        end
        return r;
    endfunction

    // Called just after a falling edge; returns just after the falling edge
    // that follows acceptance.
    task automatic drive_req(input t_tbp_req r, input bit typed, input t_tbp_rsp typed_rsp);
        t_tbp_rsp     p;
        t_lookup_snap s;
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.data = r;
        req_if.valid = 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        p = predict_branch(r);
        pending_rsp.push_back(typed ? typed_rsp : p);
        if (r.req_type == REQ_LOOKUP) begin
            s.pc = r.branch_pc;
            s.lctr = p.snap_local_ctr;
            s.gctr = p.snap_global_ctr;
            s.hist = p.snap_history;
            lookup_snaps.push_back(s);
            if (lookup_snaps.size() > SNAP_POOL_SIZE) void'(lookup_snaps.pop_front());
        end
        @(negedge i_clk);
    endtask

    task automatic drain_rsp();
        req_if.valid = 1'b0;
        while (pending_rsp.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_hist_len(input logic [LEN_W-1:0] v);
        drain_rsp();
        repeat (4) @(negedge i_clk);
        i_cfg_wdata = v;
        i_cfg_we = 1'b1;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        // The live history is cut to the new length as the register is written.
        hist_len = v;
        spec_history &= len_mask(v);
    endtask

    task automatic note_mismatch(input string field, input logic [HIST_W-1:0] exp_v,
                                 input logic [HIST_W-1:0] act_v);
        $display("%0t: %s mismatch: expected %h, got %h", $time, field, exp_v, act_v);
        err_count++;
    endtask

    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_if.ready = ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_tbp_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result: expected none, got %h", $time, rsp_if.data);
                err_count++;
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_if.data.predict_taken !== want.predict_taken) begin
                    note_mismatch("predict_taken", HIST_W'(want.predict_taken),
                                  HIST_W'(rsp_if.data.predict_taken));
                end
                if (rsp_if.data.snap_local_ctr !== want.snap_local_ctr) begin
                    note_mismatch("snap_local_ctr", HIST_W'(want.snap_local_ctr),
                                  HIST_W'(rsp_if.data.snap_local_ctr));
                end
                if (rsp_if.data.snap_global_ctr !== want.snap_global_ctr) begin
                    note_mismatch("snap_global_ctr", HIST_W'(want.snap_global_ctr),
                                  HIST_W'(rsp_if.data.snap_global_ctr));
                end
                if (rsp_if.data.snap_history !== want.snap_history) begin
                    note_mismatch("snap_history", want.snap_history,
                                  rsp_if.data.snap_history);
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        err_count = 0;
        model_reset();
        foreach (hot_pcs[i]) hot_pcs[i] = $urandom;

        // Right after reset the results can be read off directly.
        add_row(mk_req(REQ_LOOKUP, 32'h0000_0000, 1'b0, 1'b0, 2'd0, 2'd0, 16'h0000),
                1'b1, '{1'b1, 2'd2, 2'd2, 16'h0000});
        add_row(mk_req(REQ_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b0, 2'd0, 2'd0, 16'h0000),
                1'b1, '{1'b1, 2'd2, 2'd2, 16'h0001});
        add_row(mk_req(REQ_UNCOND, 32'h0000_0000, 1'b0, 1'b0, 2'd0, 2'd0, 16'h0000),
                1'b1, '{1'b1, 2'd0, 2'd0, 16'h0003});
        add_row(mk_req(REQ_SQUASH, 32'h0000_0000, 1'b0, 1'b0, 2'd0, 2'd0, 16'hFFFF),
                1'b1, '{1'b0, 2'd0, 2'd0, 16'h0007});
        add_row(mk_req(REQ_UPDATE, 32'hFFFF_FFFF, 1'b1, 1'b1, 2'd3, 2'd3, 16'hFFFF),
                1'b1, '{1'b0, 2'd0, 2'd0, 16'h0FFF});
        add_row(mk_req(REQ_SQUASH, 32'hFFFF_FFFF, 1'b1, 1'b1, 2'd3, 2'd3, 16'h0000),
                1'b1, '{1'b0, 2'd0, 2'd0, 16'h0FFF});
        // Disagreeing and agreeing updates drive the counters to both limits.
        add_row(mk_req(REQ_UPDATE, 32'h0000_0040, 1'b0, 1'b0, 2'd3, 2'd0, 16'h0000), 1'b0, '0);
        add_row(mk_req(REQ_UPDATE, 32'h0000_0040, 1'b0, 1'b0, 2'd3, 2'd0, 16'h0000), 1'b0, '0);
        add_row(mk_req(REQ_UPDATE, 32'h0000_0040, 1'b0, 1'b0, 2'd0, 2'd0, 16'h0000), 1'b0, '0);
        add_row(mk_req(REQ_LOOKUP, 32'h0000_0040, 1'b0, 1'b0, 2'd0, 2'd0, 16'h0000), 1'b0, '0);
        add_row(mk_req(REQ_UPDATE, 32'h0000_0080, 1'b1, 1'b0, 2'd0, 2'd3, 16'hFFFF), 1'b0, '0);
        add_row(mk_req(REQ_UPDATE, 32'h0000_0080, 1'b1, 1'b0, 2'd0, 2'd3, 16'hFFFF), 1'b0, '0);
        add_row(mk_req(REQ_UPDATE, 32'h0000_0080, 1'b1, 1'b0, 2'd0, 2'd3, 16'hFFFF), 1'b0, '0);
        add_row(mk_req(REQ_UPDATE, 32'h0000_0080, 1'b1, 1'b0, 2'd3, 2'd0, 16'hFFFF), 1'b0, '0);
        add_row(mk_req(REQ_UPDATE, 32'h0000_0080, 1'b0, 1'b0, 2'd3, 2'd0, 16'hFFFF), 1'b0, '0);
        add_row(mk_req(REQ_LOOKUP, 32'h0000_0080, 1'b0, 1'b0, 2'd0, 2'd0, 16'h0000), 1'b0, '0);
        add_row(mk_req(REQ_UNCOND, 32'hFFFF_FFFF, 1'b1, 1'b1, 2'd3, 2'd3, 16'hFFFF), 1'b0, '0);
        add_row(mk_req(REQ_LOOKUP, 32'h0000_0080, 1'b0, 1'b0, 2'd0, 2'd0, 16'h0000), 1'b0, '0);
        add_row(mk_req(REQ_SQUASH, 32'h0000_0000, 1'b0, 1'b0, 2'd0, 2'd0, 16'hA5A5), 1'b0, '0);
        add_row(mk_req(REQ_LOOKUP, 32'hFFFF_FFFC, 1'b0, 1'b0, 2'd0, 2'd0, 16'h0000), 1'b0, '0);
        add_row(mk_req(REQ_UPDATE, 32'h1234_5678, 1'b1, 1'b0, 2'd2, 2'd1, 16'h5A5A), 1'b0, '0);
        add_row(mk_req(REQ_LOOKUP, 32'h1234_5678, 1'b0, 1'b0, 2'd0, 2'd0, 16'h0000), 1'b0, '0);

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) drive_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].rsp);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_hist_len(len_plan[ph]);
            src_idle_pct = src_idle_plan[ph % 4];
            snk_stall_pct = snk_stall_plan[ph % 4];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph % 2 == 1 && n == PHASE_ITEMS / 2) drain_rsp();
                drive_req(gen_item(), 1'b0, '0);
            end
        end

        drain_rsp();
        repeat (20) @(negedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
